// ----- rtl/mpq_pkg.sv -----
`timescale 1ns / 1ps
package mpq_pkg;

	localparam int KEY_BITS = 32;
	localparam int TAG_W = 16;
	localparam int OCC_BITS = 7;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		FN_ENQ = 1'b0,
		FN_DEQ = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_WORK = 2'd1,
		S_OUT  = 2'd2
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    apply;
		logic    deq;
		logic    out_load;
		status_t status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		func_t func;
		logic  empty;
		logic  full;
	} stat_t;

endpackage

// ----- rtl/mpq_ctrl.sv -----
`timescale 1ns / 1ps
module mpq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          out_fire,
	input  mpq_pkg::stat_t st,
	output mpq_pkg::cmd_t  cmd,
	output logic          s_ready,
	output logic          m_valid
);

	mpq_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpq_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			mpq_pkg::S_IDLE: if (in_fire) state_next = mpq_pkg::S_WORK;
			mpq_pkg::S_WORK: state_next = mpq_pkg::S_OUT;
			mpq_pkg::S_OUT: begin
				if (out_fire) state_next = in_fire ? mpq_pkg::S_WORK : mpq_pkg::S_IDLE;
			end
			default: state_next = mpq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_ready = 1'b0;
		m_valid = 1'b0;
		case (state_q)
			mpq_pkg::S_IDLE: begin
				s_ready = 1'b1;
				cmd.load = in_fire;
			end
			mpq_pkg::S_WORK: begin
				cmd.out_load = 1'b1;
				if (st.func == mpq_pkg::FN_ENQ) begin
					cmd.status = st.full ? mpq_pkg::ST_FULL : mpq_pkg::ST_DONE;
					cmd.apply = !st.full;
				end else begin
					cmd.status = st.empty ? mpq_pkg::ST_EMPTY : mpq_pkg::ST_DONE;
					cmd.apply = !st.empty;
					cmd.deq = 1'b1;
				end
			end
			mpq_pkg::S_OUT: begin
				m_valid = 1'b1;
				s_ready = out_fire;
				cmd.load = in_fire;
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/mpq_dp.sv -----
`timescale 1ns / 1ps
module mpq_dp #(
	parameter int CAPACITY = 64,
	parameter int TAG_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mpq_pkg::cmd_t               cmd,
	input  logic                        in_func,
	input  logic [mpq_pkg::KEY_BITS-1:0] in_key,
	input  logic [mpq_pkg::TAG_W-1:0]    in_tag,
	output mpq_pkg::stat_t              st,
	output logic [1:0]                  status,
	output logic                        min_valid,
	output logic [mpq_pkg::KEY_BITS-1:0] min_key,
	output logic [mpq_pkg::TAG_W-1:0]    min_tag,
	output logic [mpq_pkg::OCC_BITS-1:0] occupancy
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int TW = (TAG_BITS < mpq_pkg::TAG_W) ? TAG_BITS : mpq_pkg::TAG_W;

	// sorted chain of cells, cell 0 holds the minimum
	logic [mpq_pkg::KEY_BITS-1:0] key_q [CAPACITY];
	logic [TW-1:0]                tag_q [CAPACITY];
	logic [CAPACITY-1:0]          vld_q;
	logic [CW-1:0]                cnt_q;
	logic                         func_q;
	logic [mpq_pkg::KEY_BITS-1:0] nkey_q;
	logic [TW-1:0]                ntag_q;
	logic [CAPACITY-1:0]          gt;

	// cell holds a key strictly greater than the new one (signed)
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			gt[i] = vld_q[i] && ($signed(key_q[i]) > $signed(nkey_q));
		end
	end

	assign st.func  = mpq_pkg::func_t'(func_q);
	assign st.empty = !vld_q[0];
	assign st.full  = vld_q[CAPACITY-1];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			nkey_q <= in_key;
			ntag_q <= in_tag[TW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			cnt_q <= '0;
		end else if (cmd.apply) begin
			if (cmd.deq) begin
				vld_q <= vld_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end else begin
				vld_q <= {vld_q[CAPACITY-2:0], 1'b1};
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// each cell looks only at itself and its neighbors
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (cmd.deq) begin
					if (i < CAPACITY - 1) begin
						key_q[i] <= key_q[(i < CAPACITY - 1) ? i + 1 : i];
						tag_q[i] <= tag_q[(i < CAPACITY - 1) ? i + 1 : i];
					end
				end else if (i == 0) begin
					if (gt[0] || !vld_q[0]) begin
						key_q[0] <= nkey_q;
						tag_q[0] <= ntag_q;
					end
				end else if (gt[i - ((i > 0) ? 1 : 0)]) begin
					key_q[i] <= key_q[i - ((i > 0) ? 1 : 0)];
					tag_q[i] <= tag_q[i - ((i > 0) ? 1 : 0)];
				end else if (gt[i] || !vld_q[i]) begin
					key_q[i] <= nkey_q;
					tag_q[i] <= ntag_q;
				end
			end
		end
	end

	// result register, taken from the chain as it stands after this beat
	logic                        nvld;
	logic [mpq_pkg::KEY_BITS-1:0] nmk;
	logic [TW-1:0]               nmt;
	logic [CW-1:0]               ncnt;

	always_comb begin
		nvld = vld_q[0];
		nmk  = key_q[0];
		nmt  = tag_q[0];
		ncnt = cnt_q;
		if (cmd.apply) begin
			if (cmd.deq) begin
				nvld = vld_q[1];
				nmk  = key_q[1];
				nmt  = tag_q[1];
				ncnt = cnt_q - 1'b1;
			end else begin
				nvld = 1'b1;
				ncnt = cnt_q + 1'b1;
				if (!vld_q[0] || gt[0]) begin
					nmk = nkey_q;
					nmt = ntag_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status    <= cmd.status;
			min_valid <= nvld;
			min_key   <= nvld ? nmk : '0;
			min_tag   <= nvld ? mpq_pkg::TAG_W'(nmt) : '0;
			occupancy <= mpq_pkg::OCC_BITS'(ncnt);
		end
	end

endmodule

// ----- rtl/min_priority_queue_core.sv -----
`timescale 1ns / 1ps
// Bounded min-priority queue built as a sorted chain of CAPACITY cells. Each
// input beat enqueues a key/tag or dequeues the minimum; one result beat per
// input gives status, the minimum after the step and the occupancy. Equal keys
// leave oldest first. The input beat is registered first; then every cell
// compares against the new key and shifts in parallel. The result register
// lets the next input be taken as the result leaves.
module min_priority_queue_core #(
	parameter int CAPACITY = 64,
	parameter int TAG_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // func[0], key[32:1], tag[48:33], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // status[1:0], min_valid[2], min_key[34:3],
	                              // min_tag[50:35], occupancy[57:51], zero pad
);

	mpq_pkg::cmd_t  cmd;
	mpq_pkg::stat_t st;
	logic in_fire, out_fire;
	logic [1:0]  status;
	logic        min_valid;
	logic [31:0] min_key;
	logic [15:0] min_tag;
	logic [6:0]  occupancy;

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	mpq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.st(st), .cmd(cmd), .s_ready(s_tready), .m_valid(m_tvalid)
	);

	mpq_dp #(.CAPACITY(CAPACITY), .TAG_BITS(TAG_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_func(s_tdata[0]), .in_key(s_tdata[32:1]), .in_tag(s_tdata[48:33]),
		.st(st), .status(status), .min_valid(min_valid), .min_key(min_key),
		.min_tag(min_tag), .occupancy(occupancy)
	);

	assign m_tdata = {6'd0, occupancy, min_tag, min_key, min_valid, status};

endmodule
